// ----- sv/tfdp_pkg.sv -----
// Shared types and constants of the tagged frame demux parser.
// Holds the queue command format, the result codes and the marker byte tables.
// No dependencies; every other file of the block refers to it by scoped names.
package tfdp_pkg;

   localparam int unsigned MarkLen    = 9;
   localparam int unsigned ThreadBits = 31;

   localparam logic [7:0] EqChar = 8'h3D;

   localparam logic [1:0] KIND_PASS    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_OK      = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_HEADER     = 3'd1;
   localparam logic [2:0] ERR_TRAILER    = 3'd2;
   localparam logic [2:0] ERR_LENGTH     = 3'd3;
   localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

   // At most one command per input beat: replay of held marker bytes, then an optional
   // closing result (the current byte or a frame status).
   typedef struct packed {
      logic [3:0]            rep_n;
      logic                  rep_end;
      logic                  has_tail;
      logic [1:0]            kind;
      logic [7:0]            data_byte;
      logic [2:0]            err;
      logic [ThreadBits-1:0] thread;
   } cmd_type;

   // Byte idx of the start marker (sel_end low) or of the end marker.
   function automatic logic [7:0] mark_byte(input logic sel_end, input logic [3:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (!sel_end) begin
         case (idx)
            4'd0: ch = "=";
            4'd1: ch = "t";
            4'd2: ch = "S";
            4'd3: ch = "a";
            4'd4: ch = "N";
            4'd5: ch = "l";
            4'd6: ch = "O";
            4'd7: ch = "g";
            4'd8: ch = " ";
            default: ch = 8'h00;
         endcase
      end else begin
         case (idx)
            4'd0: ch = "=";
            4'd1: ch = "G";
            4'd2: ch = "o";
            4'd3: ch = "L";
            4'd4: ch = "n";
            4'd5: ch = "A";
            4'd6: ch = "s";
            4'd7: ch = "T";
            4'd8: ch = " ";
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

endpackage

// ----- sv/tfdp_front.sv -----
// Front end of the parser: marker matching, number reading and frame state.
// Turns each accepted beat into at most one command for the queue.
// Depends on tfdp_pkg.
module tfdp_front #(
   parameter int unsigned COUNT_BITS  = 24,
   parameter int unsigned NUMBER_BITS = 31
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_flush,
   output logic              cmd_push,
   output tfdp_pkg::cmd_type cmd
);

   localparam int unsigned NumW = NUMBER_BITS + 5;
   localparam int unsigned CmpW = (COUNT_BITS > NUMBER_BITS) ? COUNT_BITS : NUMBER_BITS;

   typedef enum logic [3:0] {
      PH_SCAN    = 4'd0,
      PH_HEAD0   = 4'd1,
      PH_HEAD1   = 4'd2,
      PH_HEAD2   = 4'd3,
      PH_HEAD3   = 4'd4,
      PH_HEAD4   = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_TAIL0   = 4'd7,
      PH_TAIL1   = 4'd8,
      PH_TAIL2   = 4'd9,
      PH_TAIL3   = 4'd10,
      PH_TAIL4   = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      NS_CONT,
      NS_DONE,
      NS_BAD
   } numres_type;

   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_HEX = 2'd2;

   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   phase_type               phase_ff, phase_in;
   logic [3:0]              pos_ff, pos_in;
   logic [NUMBER_BITS-1:0]  acc_ff, acc_in;
   logic [1:0]              base_ff, base_in;
   logic [NUMBER_BITS-1:0]  thread_ff, thread_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   logic [2:0]              sub;
   numres_type              ns_res;
   logic [2:0]              ns_sub;
   logic [NUMBER_BITS-1:0]  ns_acc;
   logic [1:0]              ns_base;
   logic [4:0]              digit;
   logic [4:0]              radix;
   logic [NumW-1:0]         scaled;
   logic [NumW-1:0]         next_val;
   logic                    mk_end;
   logic                    go_scan;
   logic [COUNT_BITS:0]     count_sum;
   logic [COUNT_BITS-1:0]   count_sat;
   logic                    len_bad;

   function automatic logic [4:0] digit_of(input logic [7:0] b);
      logic [4:0] d;
      d = 5'd16;
      if (b >= "0" && b <= "9") d = 5'(b - "0");
      else if (b >= "a" && b <= "f") d = 5'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") d = 5'(b - "A" + 8'd10);
      return d;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == " ") || (b >= 8'd9 && b <= 8'd13);
   endfunction

   assign digit = digit_of(in_byte);
   assign sub   = (phase_ff >= PH_TAIL0) ? 3'(phase_ff - PH_TAIL0) : 3'(phase_ff - PH_HEAD0);

   always_comb begin
      unique case (base_ff)
         BASE_OCT: radix = 5'd8;
         BASE_HEX: radix = 5'd16;
         default:  radix = 5'd10;
      endcase
   end

   // Accumulator times radix by shifts, plus the new digit.
   always_comb begin
      unique case (base_ff)
         BASE_OCT: scaled = {acc_ff, 3'b000} + NumW'(0);
         BASE_HEX: scaled = NumW'({acc_ff, 4'b0000});
         default:  scaled = NumW'({acc_ff, 3'b000}) + NumW'({acc_ff, 1'b0});
      endcase
      next_val = scaled + NumW'(digit[3:0]);
   end

   // One step of the number reader: whitespace, leading zero, after 0x,
   // digits, then the skipped byte and the closing '='.
   always_comb begin
      ns_res  = NS_CONT;
      ns_sub  = sub;
      ns_acc  = acc_ff;
      ns_base = base_ff;
      unique case (sub)
         3'd0: begin
            if (is_space(in_byte)) begin
               ns_res = NS_CONT;
            end else if (in_byte == "0") begin
               ns_acc = '0;
               ns_sub = 3'd1;
            end else if (in_byte >= "1" && in_byte <= "9") begin
               ns_base = BASE_DEC;
               ns_acc  = NUMBER_BITS'(digit[3:0]);
               ns_sub  = 3'd3;
            end else begin
               ns_res = NS_BAD;
            end
         end
         3'd1: begin
            if (in_byte == "x" || in_byte == "X") begin
               ns_sub = 3'd2;
            end else if (in_byte >= "0" && in_byte <= "7") begin
               ns_base = BASE_OCT;
               ns_acc  = NUMBER_BITS'(digit[3:0]);
               ns_sub  = 3'd3;
            end else begin
               ns_sub = 3'd4;
            end
         end
         3'd2: begin
            if (!digit[4]) begin
               ns_base = BASE_HEX;
               ns_acc  = NUMBER_BITS'(digit[3:0]);
               ns_sub  = 3'd3;
            end else if (in_byte == tfdp_pkg::EqChar) begin
               ns_acc = '0;
               ns_res = NS_DONE;
            end else begin
               ns_res = NS_BAD;
            end
         end
         3'd3: begin
            if (digit < radix) begin
               if (next_val[NumW-1:NUMBER_BITS] != '0) ns_res = NS_BAD;
               else ns_acc = next_val[NUMBER_BITS-1:0];
            end else begin
               ns_sub = 3'd4;
            end
         end
         default: begin
            ns_res = (in_byte == tfdp_pkg::EqChar) ? NS_DONE : NS_BAD;
         end
      endcase
   end

   assign mk_end    = (phase_ff == PH_PAYLOAD);
   assign count_sum = {1'b0, count_ff} + (COUNT_BITS+1)'(pos_ff)
                    + (COUNT_BITS+1)'(in_byte != tfdp_pkg::EqChar);
   assign count_sat = count_sum[COUNT_BITS] ? CountMax : count_sum[COUNT_BITS-1:0];
   assign len_bad   = (count_ff == CountMax) || (CmpW'(count_ff) != CmpW'(ns_acc));

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      thread_in = thread_ff;
      count_in  = count_ff;
      go_scan   = 1'b0;
      cmd       = '0;
      cmd.thread = tfdp_pkg::ThreadBits'(thread_ff);

      if (in_flush) begin
         if (phase_ff == PH_SCAN) begin
            cmd.rep_n = pos_ff;
         end else begin
            if (mk_end) begin
               cmd.rep_n   = pos_ff;
               cmd.rep_end = 1'b1;
            end
            cmd.has_tail = 1'b1;
            cmd.kind     = tfdp_pkg::KIND_ERROR;
            cmd.err      = tfdp_pkg::ERR_UNTERMINATED;
         end
         go_scan = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_SCAN, PH_PAYLOAD: begin
               if (pos_ff < 4'(tfdp_pkg::MarkLen)
                   && in_byte == tfdp_pkg::mark_byte(mk_end, pos_ff)) begin
                  pos_in = pos_ff + 4'd1;
               end else begin
                  cmd.rep_n   = pos_ff;
                  cmd.rep_end = mk_end;
                  if (in_byte == tfdp_pkg::EqChar) begin
                     pos_in = 4'd1;
                  end else begin
                     pos_in         = 4'd0;
                     cmd.has_tail   = 1'b1;
                     cmd.kind       = mk_end ? tfdp_pkg::KIND_PAYLOAD : tfdp_pkg::KIND_PASS;
                     cmd.data_byte  = in_byte;
                  end
                  if (mk_end) count_in = count_sat;
               end
               if (pos_in == 4'(tfdp_pkg::MarkLen)) begin
                  pos_in  = 4'd0;
                  acc_in  = '0;
                  base_in = BASE_DEC;
                  if (mk_end) begin
                     phase_in = PH_TAIL0;
                  end else begin
                     thread_in = '0;
                     count_in  = '0;
                     phase_in  = PH_HEAD0;
                  end
               end
            end
            PH_HEAD0, PH_HEAD1, PH_HEAD2, PH_HEAD3, PH_HEAD4: begin
               unique case (ns_res)
                  NS_CONT: begin
                     phase_in = phase_type'(4'(PH_HEAD0) + 4'(ns_sub));
                     acc_in   = ns_acc;
                     base_in  = ns_base;
                  end
                  NS_DONE: begin
                     thread_in = ns_acc;
                     acc_in    = '0;
                     base_in   = BASE_DEC;
                     pos_in    = 4'd0;
                     phase_in  = PH_PAYLOAD;
                  end
                  default: begin
                     cmd.has_tail = 1'b1;
                     cmd.kind     = tfdp_pkg::KIND_ERROR;
                     cmd.err      = tfdp_pkg::ERR_HEADER;
                     go_scan      = 1'b1;
                  end
               endcase
            end
            PH_TAIL0, PH_TAIL1, PH_TAIL2, PH_TAIL3, PH_TAIL4: begin
               unique case (ns_res)
                  NS_CONT: begin
                     phase_in = phase_type'(4'(PH_TAIL0) + 4'(ns_sub));
                     acc_in   = ns_acc;
                     base_in  = ns_base;
                  end
                  NS_DONE: begin
                     cmd.has_tail = 1'b1;
                     cmd.kind     = len_bad ? tfdp_pkg::KIND_ERROR : tfdp_pkg::KIND_OK;
                     cmd.err      = len_bad ? tfdp_pkg::ERR_LENGTH : tfdp_pkg::ERR_NONE;
                     go_scan      = 1'b1;
                  end
                  default: begin
                     cmd.has_tail = 1'b1;
                     cmd.kind     = tfdp_pkg::KIND_ERROR;
                     cmd.err      = tfdp_pkg::ERR_TRAILER;
                     go_scan      = 1'b1;
                  end
               endcase
            end
            default: begin
               go_scan = 1'b1;
            end
         endcase
      end

      if (go_scan) begin
         phase_in  = PH_SCAN;
         pos_in    = 4'd0;
         acc_in    = '0;
         base_in   = BASE_DEC;
         thread_in = '0;
         count_in  = '0;
      end
   end

   assign cmd_push = in_valid && ((cmd.rep_n != 4'd0) || cmd.has_tail);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SCAN;
         pos_ff    <= 4'd0;
         acc_ff    <= '0;
         base_ff   <= BASE_DEC;
         thread_ff <= '0;
         count_ff  <= '0;
      end else if (in_valid) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         base_ff   <= base_in;
         thread_ff <= thread_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/tfdp_queue.sv -----
// Short command queue between the parser front end and the result sequencer.
// Registers only, read at the head pointer; depends on tfdp_pkg for the command type.
module tfdp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tfdp_pkg::cmd_type push_cmd,
   input  logic              pop,
   output tfdp_pkg::cmd_type head_cmd,
   output logic              not_empty,
   output logic              full
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   tfdp_pkg::cmd_type slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in;
   logic [PtrW-1:0]   rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CntW'(DEPTH));
   assign head_cmd  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      if (pop) rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      if (push && !pop) cnt_in = cnt_ff + CntW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(DEPTH))
      else $error("queue count above depth");

endmodule

// ----- sv/tfdp_back.sv -----
// Result sequencer: expands each queued command into result beats.
// Drives the registered result channel; depends on tfdp_pkg.
module tfdp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  tfdp_pkg::cmd_type                   cmd,
   input  logic                                cmd_valid,
   output logic                                cmd_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [7:0]                          rsp_byte,
   output logic [tfdp_pkg::ThreadBits-1:0]     rsp_thread,
   output logic [2:0]                          rsp_err,
   output logic                                rsp_last
);

   logic [3:0]                      idx_ff, idx_in;
   logic                            valid_ff, valid_in;
   logic [1:0]                      kind_ff, kind_in;
   logic [7:0]                      byte_ff, byte_in;
   logic [tfdp_pkg::ThreadBits-1:0] thread_ff, thread_in;
   logic [2:0]                      err_ff, err_in;
   logic                            last_ff, last_in;
   logic                            load;
   logic                            in_rep;

   assign load   = cmd_valid && (!valid_ff || rsp_ready);
   assign in_rep = (idx_ff < cmd.rep_n);

   always_comb begin
      if (in_rep) begin
         kind_in   = cmd.rep_end ? tfdp_pkg::KIND_PAYLOAD : tfdp_pkg::KIND_PASS;
         byte_in   = tfdp_pkg::mark_byte(cmd.rep_end, idx_ff);
         thread_in = cmd.rep_end ? cmd.thread : '0;
         err_in    = tfdp_pkg::ERR_NONE;
         last_in   = (idx_ff == cmd.rep_n - 4'd1) && !cmd.has_tail;
      end else begin
         kind_in   = cmd.kind;
         byte_in   = cmd.data_byte;
         thread_in = (cmd.kind == tfdp_pkg::KIND_PASS) ? '0 : cmd.thread;
         err_in    = cmd.err;
         last_in   = 1'b1;
      end
      cmd_pop  = load && last_in;
      idx_in   = cmd_pop ? 4'd0 : (load ? idx_ff + 4'd1 : idx_ff);
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         thread_ff <= thread_in;
         err_ff    <= err_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_thread = thread_ff;
   assign rsp_err    = err_ff;
   assign rsp_last   = last_ff;

   a_pass_no_thread: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == tfdp_pkg::KIND_PASS) |-> (thread_ff == '0))
      else $error("passthrough beat carries a thread id");

   a_status_no_byte: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == tfdp_pkg::KIND_OK || kind_ff == tfdp_pkg::KIND_ERROR))
      |-> (byte_ff == 8'h00))
      else $error("status beat carries a data byte");

   a_err_only_on_error: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((err_ff != tfdp_pkg::ERR_NONE) == (kind_ff == tfdp_pkg::KIND_ERROR)))
      else $error("error code does not match the result kind");

   a_idx_resets_on_pop: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (idx_ff == 4'd0))
      else $error("replay index not cleared after a command completed");

endmodule

// ----- sv/tagged_frame_demux_parser_core.sv -----
// Top level of the tagged frame demux parser: front end, command queue, sequencer.
// Depends on tfdp_pkg, tfdp_front, tfdp_queue and tfdp_back.
//
// Usage: bytes of a log stream enter on the req_ channel, one beat per byte.
// A beat with req_tuser (flush) set ends the stream; its data byte is ignored.
// Every beat produces zero or more result beats on the rsp_ channel, and the
// final result beat caused by an input beat carries rsp_tlast. Bytes outside
// frames come out as passthrough beats, payload bytes come out tagged with the
// frame's thread number, and each frame closes with one status beat.
// Bytes that could start a marker are held back; when the match fails they are
// replayed from the constant marker, so one input beat may cause up to nine
// result beats, one per cycle from the sequencer while the receiver is ready.
// The command of an accepted beat is written into the command queue, and the
// sequencer then loads its first result into the result register. Throughput
// is one input beat per cycle while each beat yields at most one result and
// the receiver is ready; replay bursts are absorbed by the command queue
// (QUEUE_DEPTH entries), and req_tready drops only while that queue is full.
// When the receiver stalls, the result register holds its beat and the queue
// fills, after which the input side stalls too. Synchronous reset returns the
// parser to scanning outside any frame and empties the queue and result stage.
module tagged_frame_demux_parser_core #(
   parameter int unsigned COUNT_BITS  = 24,
   parameter int unsigned NUMBER_BITS = 31,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [0:0]  req_tuser,   // [0] flush
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_byte, [38:8] thread_id, [41:39] error_code,
                                    // [47:42] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last result of the input beat
);

   logic              accept;
   logic              cmd_push;
   tfdp_pkg::cmd_type push_cmd;
   tfdp_pkg::cmd_type head_cmd;
   logic              head_valid;
   logic              queue_full;
   logic              cmd_pop;
   logic [1:0]        out_kind;
   logic [7:0]        out_byte;
   logic [tfdp_pkg::ThreadBits-1:0] out_thread;
   logic [2:0]        out_err;

   // The front end only needs room for one command per beat.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   tfdp_front #(
      .COUNT_BITS  (COUNT_BITS),
      .NUMBER_BITS (NUMBER_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_byte  (req_tdata),
      .in_flush (req_tuser[0]),
      .cmd_push (cmd_push),
      .cmd      (push_cmd)
   );

   tfdp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .pop       (cmd_pop),
      .head_cmd  (head_cmd),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   tfdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (head_cmd),
      .cmd_valid  (head_valid),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_kind   (out_kind),
      .rsp_byte   (out_byte),
      .rsp_thread (out_thread),
      .rsp_err    (out_err),
      .rsp_last   (rsp_tlast)
   );

   // Pack the result fields from the lowest bit up, zero filled to six bytes.
   assign rsp_tdata = {6'b000000, out_err, out_thread, out_byte};
   assign rsp_tuser = out_kind;

endmodule
